>>> rtl/linear_scan_min_priority_queue_top_macros.svh
// Assertion macros shared by the frontier queue RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef LINEAR_SCAN_MIN_PRIORITY_QUEUE_TOP_MACROS_SVH
`define LINEAR_SCAN_MIN_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LSMPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LSMPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/lsmpq_pkg.sv
// Shared types, sizes and codes for the frontier queue.
// No dependencies; used by the interfaces, the entry store and the top level.
package lsmpq_pkg;

   // Sizes
   localparam int DEPTH      = 64;
   localparam int BOARD_BITS = 36;
   localparam int BOARD_W    = 36;  // port width of the board fields
   localparam int KEY_W      = 8;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int WIDE_W     = (BOARD_BITS > BOARD_W) ? BOARD_BITS : BOARD_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // Request codes
   typedef enum logic [1:0] {
      REQ_PUSH     = 2'd0,
      REQ_POP      = 2'd1,
      REQ_CONTAINS = 2'd2
   } req_code_type;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // One stored entry
   typedef struct packed {
      logic [KEY_W-1:0]      key;
      logic [BOARD_BITS-1:0] board;
   } entry_type;

   // Write port of the entry store
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } store_wr_type;

   // Port board code to stored width (upper bits dropped)
   function automatic logic [BOARD_BITS-1:0] to_store(input logic [BOARD_W-1:0] b);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(b);
      return wide[BOARD_BITS-1:0];
   endfunction

   // Stored board code back to port width (zero extended)
   function automatic logic [BOARD_W-1:0] from_store(input logic [BOARD_BITS-1:0] s);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(s);
      return wide[BOARD_W-1:0];
   endfunction

endpackage

>>> rtl/lsmpq_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on lsmpq_pkg for field widths.
interface lsmpq_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       req_type;
   logic [lsmpq_pkg::BOARD_W-1:0]    board_code;
   logic [lsmpq_pkg::KEY_W-1:0]      entry_key;

   modport source (output valid, req_type, board_code, entry_key, input ready);
   modport sink   (input valid, req_type, board_code, entry_key, output ready);
endinterface

interface lsmpq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lsmpq_pkg::BOARD_W-1:0]    out_board;
   logic [lsmpq_pkg::KEY_W-1:0]      out_key;
   logic                             found;
   logic [1:0]                       status;
   logic                             now_empty;

   modport source (output valid, out_board, out_key, found, status, now_empty,
                   input ready);
   modport sink   (input valid, out_board, out_key, found, status, now_empty,
                   output ready);
endinterface

>>> rtl/linear_scan_min_priority_queue_top.sv
// Frontier queue: entries kept in insertion order in one single-port-read
// memory. A push, a pop or a contains on an empty store and an unused request
// go straight from the request to the result state. A contains query reads
// every stored entry; a pop reads every stored entry and then moves the
// entries behind the removed one down by one place: the memory delivers one
// entry per cycle, first for the scan and then, on a pop, for the move. The
// result may wait for rsp_bus.ready, and no new request is taken until the
// current one has loaded its result.
// Depends on lsmpq_pkg, the channel interfaces, lsmpq_store and the macro header.
`include "linear_scan_min_priority_queue_top_macros.svh"

module linear_scan_min_priority_queue_top (
   input  logic          clock,
   input  logic          reset,
   lsmpq_req_if.sink     req_bus,
   lsmpq_rsp_if.source   rsp_bus
);

   localparam int ADDR_W = lsmpq_pkg::ADDR_W;
   localparam int CNT_W  = lsmpq_pkg::CNT_W;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_DONE} state_type;

   state_type                        state_ff, state_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [1:0]                       op_ff, op_in;
   logic [lsmpq_pkg::BOARD_BITS-1:0] board_ff, board_in;
   logic [CNT_W-1:0]                 rd_ptr_ff, rd_ptr_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]                rd_idx_ff, rd_idx_in;
   logic [ADDR_W-1:0]                best_idx_ff, best_idx_in;
   lsmpq_pkg::entry_type             best_ff, best_in;
   logic                             found_ff, found_in;
   logic [1:0]                       status_ff, status_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lsmpq_pkg::BOARD_W-1:0]    rsp_board_ff, rsp_board_in;
   logic [lsmpq_pkg::KEY_W-1:0]      rsp_key_ff, rsp_key_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [1:0]                       rsp_status_ff, rsp_status_in;
   logic                             rsp_empty_ff, rsp_empty_in;

   logic                    accept;
   logic                    rsp_free;
   logic                    rd_issue;
   logic                    pop_ok;
   lsmpq_pkg::store_wr_type wr_req;
   lsmpq_pkg::entry_type    rd_data;

   lsmpq_store u_store (
      .clock   (clock),
      .wr_req  (wr_req),
      .rd_addr (rd_ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Handshake
   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign rd_issue      = ((state_ff == S_SCAN) || (state_ff == S_SHIFT))
                          && (rd_ptr_ff < count_ff);
   assign pop_ok        = (op_ff == lsmpq_pkg::REQ_POP) && (status_ff == lsmpq_pkg::STATUS_OK);

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_board = rsp_board_ff;
   assign rsp_bus.out_key   = rsp_key_ff;
   assign rsp_bus.found     = rsp_found_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.now_empty = rsp_empty_ff;

   // Next-state and datapath
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      board_in      = board_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_ptr_ff[ADDR_W-1:0];
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_board_in  = rsp_board_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      wr_req        = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_bus.req_type;
               board_in  = lsmpq_pkg::to_store(req_bus.board_code);
               found_in  = 1'b0;
               status_in = lsmpq_pkg::STATUS_OK;
               rd_ptr_in = '0;
               state_in  = S_DONE;
               if (req_bus.req_type == lsmpq_pkg::REQ_PUSH) begin
                  if (count_ff == lsmpq_pkg::DEPTH_CNT) begin
                     status_in = lsmpq_pkg::STATUS_FULL;
                  end else begin
                     // append at the tail
                     wr_req.en         = 1'b1;
                     wr_req.addr       = count_ff[ADDR_W-1:0];
                     wr_req.data.key   = req_bus.entry_key;
                     wr_req.data.board = lsmpq_pkg::to_store(req_bus.board_code);
                     count_in          = count_ff + CNT_W'(1);
                  end
               end else if (req_bus.req_type == lsmpq_pkg::REQ_POP) begin
                  if (count_ff == '0) begin
                     status_in = lsmpq_pkg::STATUS_EMPTY;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else if (req_bus.req_type == lsmpq_pkg::REQ_CONTAINS) begin
                  if (count_ff != '0) begin
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            // stream reads, one entry per cycle
            if (rd_issue) begin
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               if (op_ff == lsmpq_pkg::REQ_POP) begin
                  // strict compare keeps the earliest entry on a tie
                  if ((rd_idx_ff == '0) || (rd_data.key < best_ff.key)) begin
                     best_idx_in = rd_idx_ff;
                     best_in     = rd_data;
                  end
               end else if (rd_data.board == board_ff) begin
                  found_in = 1'b1;
               end
            end
            if (!rd_issue && !rd_vld_ff) begin
               if (op_ff == lsmpq_pkg::REQ_POP) begin
                  rd_ptr_in = CNT_W'(best_idx_ff) + CNT_W'(1);
                  state_in  = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SHIFT: begin
            // move each entry behind the removed one down by one place
            if (rd_issue) begin
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               wr_req.en   = 1'b1;
               wr_req.addr = rd_idx_ff - ADDR_W'(1);
               wr_req.data = rd_data;
            end
            if (!rd_issue && !rd_vld_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // load the output register once it is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_board_in  = pop_ok ? lsmpq_pkg::from_store(best_ff.board) : '0;
               rsp_key_in    = pop_ok ? best_ff.key : '0;
               rsp_found_in  = found_ff;
               rsp_status_in = status_ff;
               rsp_empty_in  = (count_ff == '0);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      board_ff      <= board_in;
      rd_ptr_ff     <= rd_ptr_in;
      rd_idx_ff     <= rd_idx_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_board_ff  <= rsp_board_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // Checks
   `LSMPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      count_ff <= lsmpq_pkg::DEPTH_CNT, "entry count above depth")
   `LSMPQ_ASSERT_NOW(a_shift_wr_in_range, clock, reset, (state_ff == S_SHIFT) && wr_req.en,
      (CNT_W'(wr_req.addr) + CNT_W'(1)) < count_ff, "shift writes outside stored entries")
   `LSMPQ_ASSERT_NOW(a_rd_vld_in_walk, clock, reset, rd_vld_ff,
      (state_ff == S_SCAN) || (state_ff == S_SHIFT), "read data pending outside a walk")
   `LSMPQ_ASSERT_NEXT(a_push_grows, clock, reset,
      accept && (req_bus.req_type == lsmpq_pkg::REQ_PUSH) && (count_ff != lsmpq_pkg::DEPTH_CNT),
      count_ff == ($past(count_ff) + CNT_W'(1)), "push did not grow the store")

endmodule

>>> rtl/lsmpq_store.sv
// Entry store: one write port, one read port, registered read data.
// Depends on lsmpq_pkg for the entry and write-port types.
module lsmpq_store (
   input  logic                            clock,
   input  lsmpq_pkg::store_wr_type         wr_req,
   input  logic [lsmpq_pkg::ADDR_W-1:0]    rd_addr,
   output lsmpq_pkg::entry_type            rd_data
);

   lsmpq_pkg::entry_type mem_ff [lsmpq_pkg::DEPTH];
   lsmpq_pkg::entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem_ff[wr_req.addr] <= wr_req.data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> dv/linear_scan_min_priority_queue_top_tb.sv
// Self-checking testbench for the min-key frontier queue: directed and random
// push/pop/contains traffic with random stalls on both channels.
// Depends on lsmpq_pkg, the channel interfaces and linear_scan_min_priority_queue_top.
module linear_scan_min_priority_queue_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = lsmpq_pkg::DEPTH;
   localparam int BOARD_BITS = lsmpq_pkg::BOARD_BITS;
   localparam int BOARD_W    = lsmpq_pkg::BOARD_W;
   localparam int KEY_W      = lsmpq_pkg::KEY_W;

   // Request code that the block answers without changing the store
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int  RANDOM_ITEMS = 750;
   localparam int  DRAIN_CYCLES = 2 * DEPTH + 16;
   localparam int  CYCLE_LIMIT  = 1_000_000;
   localparam int  IDLE_PCT     = 31;
   localparam logic [BOARD_W-1:0] BOARD_KEEP = BOARD_W'((65'd1 << BOARD_BITS) - 65'd1);

   typedef struct packed {
      logic [1:0]         kind;
      logic [BOARD_W-1:0] board;
      logic [KEY_W-1:0]   key;
   } frontier_req_type;

   typedef struct packed {
      logic [BOARD_W-1:0] out_board;
      logic [KEY_W-1:0]   out_key;
      logic               found;
      logic [1:0]         status;
      logic               now_empty;
   } frontier_rsp_type;

   logic clock;
   logic reset = 1'b1;

   lsmpq_req_if req_bus ();
   lsmpq_rsp_if rsp_bus ();

   linear_scan_min_priority_queue_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predicted frontier contents, in insertion order
   logic [BOARD_W-1:0] board_mem [DEPTH];
   logic [KEY_W-1:0]   key_mem [DEPTH];
   int                 held_cnt = 0;

   frontier_req_type   pending_reqs [$];
   frontier_rsp_type   expected_rsps [$];
   frontier_req_type   in_flight;
   int                 total_reqs = 0;
   int                 accepted_cnt = 0;
   int                 mismatch_cnt = 0;
   int                 cycle_cnt = 0;
   logic               calm;

   // Stimulus bookkeeping: occupancy seen by the generator, recent boards
   int                 gen_fill = 0;
   int                 real_items = 0;
   logic [BOARD_W-1:0] recent_boards [$];

   // No idling on either side for a stretch of transfers
   assign calm = (accepted_cnt >= 300) && (accepted_cnt < 420);

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Reset, held from the start of the run
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Predictor: applies one request to the frontier copy, returns the response
   function automatic frontier_rsp_type frontier_apply(frontier_req_type r);
      frontier_rsp_type   o;
      logic [BOARD_W-1:0] b;
      int                 best;
      o = '0;
      b = r.board & BOARD_KEEP;
      o.status = lsmpq_pkg::STATUS_OK;
      case (r.kind)
         lsmpq_pkg::REQ_PUSH: begin
            if (held_cnt >= DEPTH) begin
               o.status = lsmpq_pkg::STATUS_FULL;
            end else begin
               board_mem[held_cnt] = b;
               key_mem[held_cnt]   = r.key;
               held_cnt++;
            end
         end
         lsmpq_pkg::REQ_POP: begin
            if (held_cnt == 0) begin
               o.status = lsmpq_pkg::STATUS_EMPTY;
            end else begin
               // strict less-than keeps the earliest entry on a tie
               best = 0;
               for (int i = 1; i < held_cnt; i++)
                  if (key_mem[i] < key_mem[best]) best = i;
               o.out_board = board_mem[best];
               o.out_key   = key_mem[best];
               for (int i = best; i + 1 < held_cnt; i++) begin
                  board_mem[i] = board_mem[i + 1];
                  key_mem[i]   = key_mem[i + 1];
               end
               held_cnt--;
            end
         end
         lsmpq_pkg::REQ_CONTAINS: begin
            for (int i = 0; i < held_cnt; i++)
               if (board_mem[i] == b) o.found = 1'b1;
         end
         default: ;
      endcase
      o.now_empty = (held_cnt == 0);
      return o;
   endfunction

   function automatic void queue_item(logic [1:0] kind, logic [BOARD_W-1:0] board,
                                      logic [KEY_W-1:0] key);
      frontier_req_type r;
      r.kind  = kind;
      r.board = board;
      r.key   = key;
      pending_reqs = {pending_reqs, r};
      if (kind == lsmpq_pkg::REQ_PUSH) begin
         if (gen_fill < DEPTH) gen_fill++;
         recent_boards = {recent_boards, board};
         if (recent_boards.size() > 32) void'(recent_boards.pop_front());
      end else if (kind == lsmpq_pkg::REQ_POP && gen_fill > 0) begin
         gen_fill--;
      end
      if (kind != REQ_UNUSED) real_items++;
   endfunction

   function automatic logic [BOARD_W-1:0] pick_board(int reuse_pct);
      if (recent_boards.size() > 0 && $urandom_range(0, 99) < reuse_pct)
         return recent_boards[$urandom_range(0, recent_boards.size() - 1)];
      return BOARD_W'({$urandom(), $urandom()});
   endfunction

   // Narrow keys half the time so ties are common
   function automatic void random_push();
      logic [KEY_W-1:0] k;
      k = ($urandom_range(0, 1) == 0) ? KEY_W'($urandom_range(0, 7))
                                      : KEY_W'($urandom_range(0, 255));
      queue_item(lsmpq_pkg::REQ_PUSH, pick_board(20), k);
   endfunction

   function automatic void random_probe();
      queue_item(lsmpq_pkg::REQ_CONTAINS, pick_board(60), KEY_W'($urandom()));
   endfunction

   function automatic void random_pop();
      queue_item(lsmpq_pkg::REQ_POP, BOARD_W'({$urandom(), $urandom()}), KEY_W'($urandom()));
   endfunction

   // Stimulus generation, then end-of-test
   initial begin
      int pick;
      int extra;

      // Directed: empty-store cases, extremes, ties, hits and misses
      queue_item(lsmpq_pkg::REQ_POP, '0, '0);
      queue_item(lsmpq_pkg::REQ_CONTAINS, '0, '0);
      queue_item(REQ_UNUSED, '1, '1);
      queue_item(lsmpq_pkg::REQ_PUSH, '0, 8'hFF);
      queue_item(lsmpq_pkg::REQ_PUSH, '1, 8'h00);
      queue_item(lsmpq_pkg::REQ_PUSH, BOARD_W'(36'hA5A5A5A5A), 8'h00);
      queue_item(lsmpq_pkg::REQ_PUSH, BOARD_W'(36'h5A5A5A5A5), 8'h80);
      queue_item(lsmpq_pkg::REQ_CONTAINS, '1, 8'hFF);
      queue_item(lsmpq_pkg::REQ_CONTAINS, '0, 8'h00);
      queue_item(lsmpq_pkg::REQ_CONTAINS, BOARD_W'(36'h123456789), 8'h00);
      queue_item(REQ_UNUSED, BOARD_W'(36'h5A5A5A5A5), 8'h01);
      queue_item(lsmpq_pkg::REQ_POP, '1, '1);
      queue_item(lsmpq_pkg::REQ_POP, '0, '0);
      queue_item(lsmpq_pkg::REQ_PUSH, BOARD_W'(36'h000000001), 8'hFF);
      queue_item(lsmpq_pkg::REQ_POP, '0, '0);
      queue_item(lsmpq_pkg::REQ_POP, '0, '0);
      queue_item(lsmpq_pkg::REQ_CONTAINS, BOARD_W'(36'h000000001), 8'h00);
      queue_item(lsmpq_pkg::REQ_POP, '0, '0);
      queue_item(lsmpq_pkg::REQ_POP, '0, '0);
      queue_item(lsmpq_pkg::REQ_CONTAINS, '1, 8'h00);
      real_items = 0;

      // Random episodes: fill past full, drain past empty, or mixed traffic
      while (real_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 3);
         if (pick == 0) begin
            while (gen_fill < DEPTH) begin
               if ($urandom_range(0, 99) < 15) random_probe();
               else random_push();
            end
            extra = $urandom_range(1, 3);
            repeat (extra) random_push();
         end else if (pick == 1) begin
            while (gen_fill > 0) begin
               if ($urandom_range(0, 99) < 15) random_probe();
               else random_pop();
            end
            extra = $urandom_range(1, 2);
            repeat (extra) queue_item(lsmpq_pkg::REQ_POP, '0, '0);
         end else begin
            repeat (30) begin
               pick = $urandom_range(0, 99);
               if (pick < 45) random_push();
               else if (pick < 80) random_pop();
               else if (pick < 95) random_probe();
               else queue_item(REQ_UNUSED, pick_board(50), KEY_W'($urandom()));
            end
         end
      end
      total_reqs = pending_reqs.size();

      // Wait for every transfer and every response, then let the block settle
      while (accepted_cnt < total_reqs) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0 && expected_rsps.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Timeout
   initial begin
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Mismatches found");
      $finish;
   end

   // Request driver: predicts on each transfer, then offers the next item
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.req_type   <= lsmpq_pkg::REQ_PUSH;
         req_bus.board_code <= '0;
         req_bus.entry_key  <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_rsps = {expected_rsps, frontier_apply(in_flight)};
            accepted_cnt <= accepted_cnt + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               in_flight = pending_reqs.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.req_type   <= in_flight.kind;
               req_bus.board_code <= in_flight.board;
               req_bus.entry_key  <= in_flight.key;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_cnt++;
      end
   endfunction

   // Response monitor: compares each transfer with the oldest prediction
   always @(posedge clock) begin
      frontier_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual board %0h key %0h",
                        $time, rsp_bus.out_board, rsp_bus.out_key);
               mismatch_cnt++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("out_board", 64'(want.out_board), 64'(rsp_bus.out_board));
               check_field("out_key", 64'(want.out_key), 64'(rsp_bus.out_key));
               check_field("found", 64'(want.found), 64'(rsp_bus.found));
               check_field("status", 64'(want.status), 64'(rsp_bus.status));
               check_field("now_empty", 64'(want.now_empty), 64'(rsp_bus.now_empty));
            end
         end
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

endmodule
